/* rtl/ttac_pkg.sv */
// ----------------------------------------------------------------------------
// ttac_pkg
// Shared widths, register indexes, mode codes and the configuration bundle
// for the tilted tapered aperture check.
// ----------------------------------------------------------------------------
package ttac_pkg;

  // Coordinate and trig formats
  localparam int COORD_WIDTH    = 32;  // pos_x / pos_y, signed nm
  localparam int TRIG_FRAC_BITS = 30;  // fractional bits of cos / sin
  localparam int HALF_W         = 32;  // each half of a 64-bit register
  localparam int TRIG_W         = 32;  // cos / sin field width
  localparam int Z_W            = 32;  // pos_z width

  // Configuration port
  localparam int CFG_W = 64;
  localparam int IDX_W = 3;

  // Taper fraction, unsigned Q1.16 saturated at 1.0
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

  // Interpolation products
  localparam int DIFF_W  = HALF_W + 1;
  localparam int LERP_W  = FRAC_W + 1 + DIFF_W;
  localparam int SHIFT_W = LERP_W - FRAC_BITS;

  // Offset-corrected point, clamped to [-2^34, 2^34 - 1]
  localparam int UV_W  = 35;
  localparam int SUM_W = ((COORD_WIDTH > SHIFT_W) ? COORD_WIDTH : SHIFT_W) + 2;

  // Rotation
  localparam int PROD_W = UV_W + TRIG_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int X1_W   = ACC_W - TRIG_FRAC_BITS;
  localparam int CMP_W  = X1_W + 2;

  // Accept to result strobe, in clock edges
  localparam int LATENCY = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_ROTATION     = 3'd1,
    REG_INV_LENGTH   = 3'd2,
    REG_ENTRY_SIZE   = 3'd3,
    REG_EXIT_SIZE    = 3'd4,
    REG_ENTRY_OFFSET = 3'd5,
    REG_EXIT_OFFSET  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TAPERED   = 2'd0,
    MODE_UNALIGNED = 2'd1,
    MODE_POS_JAW   = 2'd2,
    MODE_NEG_JAW   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [TRIG_W-1:0]  cos_v;    // cos(-tilt)
    logic signed [TRIG_W-1:0]  sin_v;    // sin(-tilt)
    logic        [HALF_W-1:0]  inv_len;  // 2^48 / length
    logic        [HALF_W-1:0]  wid0;     // entry full width
    logic        [HALF_W-1:0]  hgt0;     // entry full height
    logic signed [HALF_W-1:0]  offx0;    // entry x offset
    logic signed [HALF_W-1:0]  offy0;    // entry y offset
    logic signed [DIFF_W-1:0]  d_offx;   // entry - exit
    logic signed [DIFF_W-1:0]  d_offy;   // entry - exit
    logic signed [DIFF_W-1:0]  d_wid;    // exit - entry
    logic signed [DIFF_W-1:0]  d_hgt;    // exit - entry
  } cfg_t;

  // Clamp a wide signed sum into the UV_W range
  function automatic logic signed [UV_W-1:0] sat_uv(input logic signed [SUM_W-1:0] a);
    logic [SUM_W-UV_W:0] top;
    top = a[SUM_W-1:UV_W-1];
    if ((top == '0) || (top == '1)) begin
      sat_uv = a[UV_W-1:0];
    end else if (a[SUM_W-1]) begin
      sat_uv = {1'b1, {(UV_W-1){1'b0}}};
    end else begin
      sat_uv = {1'b0, {(UV_W-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/ttac_cfg.sv */
// ----------------------------------------------------------------------------
// ttac_cfg
// Configuration register file; also keeps the entry/exit differences
// registered so the taper multipliers see them directly.
// ----------------------------------------------------------------------------
module ttac_cfg import ttac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output cfg_t             cfg
);

  mode_t            mode;
  logic [CFG_W-1:0] rotation;
  logic [HALF_W-1:0] inv_len;
  logic [CFG_W-1:0] entry_size;
  logic [CFG_W-1:0] exit_size;
  logic [CFG_W-1:0] entry_offset;
  logic [CFG_W-1:0] exit_offset;

  logic signed [DIFF_W-1:0] d_offx, d_offy, d_wid, d_hgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_UNALIGNED;
      rotation     <= CFG_W'(longint'(1) << TRIG_FRAC_BITS);
      inv_len      <= '0;
      entry_size   <= '0;
      exit_size    <= '0;
      entry_offset <= '0;
      exit_offset  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MODE:         mode         <= mode_t'(wr_data[1:0]);
        REG_ROTATION:     rotation     <= wr_data;
        REG_INV_LENGTH:   inv_len      <= wr_data[HALF_W-1:0];
        REG_ENTRY_SIZE:   entry_size   <= wr_data;
        REG_EXIT_SIZE:    exit_size    <= wr_data;
        REG_ENTRY_OFFSET: entry_offset <= wr_data;
        REG_EXIT_OFFSET:  exit_offset  <= wr_data;
        default: ;
      endcase
    end
  end

  // Diffs registered; user ensures config only changes when idle, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      d_offx <= '0;
      d_offy <= '0;
      d_wid  <= '0;
      d_hgt  <= '0;
    end else begin
      d_offx <= DIFF_W'($signed(entry_offset[HALF_W-1:0]))
              - DIFF_W'($signed(exit_offset[HALF_W-1:0]));
      d_offy <= DIFF_W'($signed(entry_offset[CFG_W-1:HALF_W]))
              - DIFF_W'($signed(exit_offset[CFG_W-1:HALF_W]));
      d_wid  <= $signed({1'b0, exit_size[HALF_W-1:0]})
              - $signed({1'b0, entry_size[HALF_W-1:0]});
      d_hgt  <= $signed({1'b0, exit_size[CFG_W-1:HALF_W]})
              - $signed({1'b0, entry_size[CFG_W-1:HALF_W]});
    end
  end

  always_comb begin
    cfg.mode    = mode;
    cfg.cos_v   = $signed(rotation[TRIG_W-1:0]);
    cfg.sin_v   = $signed(rotation[CFG_W-1:HALF_W]);
    cfg.inv_len = inv_len;
    cfg.wid0    = entry_size[HALF_W-1:0];
    cfg.hgt0    = entry_size[CFG_W-1:HALF_W];
    cfg.offx0   = $signed(entry_offset[HALF_W-1:0]);
    cfg.offy0   = $signed(entry_offset[CFG_W-1:HALF_W]);
    cfg.d_offx  = d_offx;
    cfg.d_offy  = d_offy;
    cfg.d_wid   = d_wid;
    cfg.d_hgt   = d_hgt;
  end

endmodule

/* rtl/ttac_rot.sv */
// ----------------------------------------------------------------------------
// ttac_rot
// Two-stage rotation: four signed products, then sum/difference and the
// floor shift by the trig fraction.
// ----------------------------------------------------------------------------
module ttac_rot import ttac_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [UV_W-1:0]   u,
  input  logic signed [UV_W-1:0]   v,
  input  logic signed [TRIG_W-1:0] cos_v,
  input  logic signed [TRIG_W-1:0] sin_v,
  output logic                     out_valid,
  output logic signed [X1_W-1:0]   x1,
  output logic signed [X1_W-1:0]   y1
);

  logic                     p_valid;
  logic signed [PROD_W-1:0] uc, vs, us, vc;
  logic signed [ACC_W-1:0]  acc_x, acc_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  // products
  always_ff @(posedge clk) begin
    uc <= PROD_W'(u) * PROD_W'(cos_v);
    vs <= PROD_W'(v) * PROD_W'(sin_v);
    us <= PROD_W'(u) * PROD_W'(sin_v);
    vc <= PROD_W'(v) * PROD_W'(cos_v);
  end

  assign acc_x = ACC_W'(uc) - ACC_W'(vs);
  assign acc_y = ACC_W'(us) + ACC_W'(vc);

  // arithmetic shift == floor division
  always_ff @(posedge clk) begin
    x1 <= acc_x[ACC_W-1:TRIG_FRAC_BITS];
    y1 <= acc_y[ACC_W-1:TRIG_FRAC_BITS];
  end

endmodule

/* rtl/tilted_tapered_aperture_check.sv */
// ----------------------------------------------------------------------------
// tilted_tapered_aperture_check
// Strict inside test of a point against a tilted, optionally tapered,
// rectangular collimator opening.
// ----------------------------------------------------------------------------
// Usage: pulse start with pos_x/pos_y/pos_z; a request is taken at every
// clock edge where start is high and busy is low, so one request per clock
// is sustained. busy is high only while rst is held. Each request produces
// exactly one answer on inside_res, flagged by done for a single cycle, in
// request order. The receiver cannot stall the block and does not need to:
// the pipeline never holds. Its stages hold the chain z * inverse_length,
// the taper multipliers, and the two-step rotation multiply/add. Registers
// are written through wr_en / wr_index / wr_data and must only change while
// no request is in flight.
// ----------------------------------------------------------------------------
module tilted_tapered_aperture_check import ttac_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic        [Z_W-1:0]         pos_z,
  output logic                          done,
  output logic                          inside_res,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_index,
  input  logic [CFG_W-1:0]              wr_data
);

  cfg_t cfg;

  ttac_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // No backpressure anywhere; only reset keeps requests out.
  assign busy = rst;

  // Stage valids
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic rot_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      done     <= rot_valid;
    end
  end

  // ---- s1: capture request ----
  logic signed [COORD_WIDTH-1:0] s1_x, s1_y;
  logic        [Z_W-1:0]         s1_z;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_z <= pos_z;
    end
  end

  // ---- s2: z * inverse_length, keep the high word ----
  logic [Z_W+HALF_W-1:0]         zprod;
  logic [HALF_W-1:0]             s2_fhi;
  logic signed [COORD_WIDTH-1:0] s2_x, s2_y;

  assign zprod = (Z_W+HALF_W)'(s1_z) * (Z_W+HALF_W)'(cfg.inv_len);

  always_ff @(posedge clk) begin
    s2_fhi <= zprod[Z_W+HALF_W-1:Z_W];
    s2_x   <= s1_x;
    s2_y   <= s1_y;
  end

  // ---- s3: taper fraction; saturates at 1.0 past the exit.
  // Untapered modes use f = 0, which yields exactly the entry values. ----
  logic [FRAC_W-1:0]             s3_f;
  logic signed [COORD_WIDTH-1:0] s3_x, s3_y;

  always_ff @(posedge clk) begin
    if (cfg.mode != MODE_TAPERED) begin
      s3_f <= '0;
    end else if (s2_fhi > HALF_W'(FRAC_ONE)) begin
      s3_f <= FRAC_W'(FRAC_ONE);
    end else begin
      s3_f <= s2_fhi[FRAC_W-1:0];
    end
    s3_x <= s2_x;
    s3_y <= s2_y;
  end

  // ---- s4: f times the entry/exit differences ----
  logic signed [FRAC_W:0]        fs;
  logic signed [LERP_W-1:0]      s4_mx, s4_my, s4_mw, s4_mh;
  logic signed [COORD_WIDTH-1:0] s4_x, s4_y;

  assign fs = $signed({1'b0, s3_f});

  always_ff @(posedge clk) begin
    s4_mx <= LERP_W'(fs) * LERP_W'(cfg.d_offx);
    s4_my <= LERP_W'(fs) * LERP_W'(cfg.d_offy);
    s4_mw <= LERP_W'(fs) * LERP_W'(cfg.d_wid);
    s4_mh <= LERP_W'(fs) * LERP_W'(cfg.d_hgt);
    s4_x  <= s3_x;
    s4_y  <= s3_y;
  end

  // ---- s5: floor shift, apply offset, interpolate sizes ----
  logic signed [SHIFT_W-1:0] shx, shy, shw, shh;
  logic signed [SUM_W-1:0]   sum_u, sum_v;
  logic signed [SHIFT_W-1:0] wid_full, hgt_full;
  logic signed [UV_W-1:0]    s5_u, s5_v;
  logic        [HALF_W-1:0]  s5_w, s5_h;

  assign shx = s4_mx[LERP_W-1:FRAC_BITS];
  assign shy = s4_my[LERP_W-1:FRAC_BITS];
  assign shw = s4_mw[LERP_W-1:FRAC_BITS];
  assign shh = s4_mh[LERP_W-1:FRAC_BITS];

  // u = x + (f*(entry-exit) >> 16) - entry
  assign sum_u = SUM_W'(s4_x) + SUM_W'(shx) - SUM_W'(cfg.offx0);
  assign sum_v = SUM_W'(s4_y) + SUM_W'(shy) - SUM_W'(cfg.offy0);

  // interpolated size stays between entry and exit, fits unsigned HALF_W
  assign wid_full = shw + $signed(SHIFT_W'(cfg.wid0));
  assign hgt_full = shh + $signed(SHIFT_W'(cfg.hgt0));

  always_ff @(posedge clk) begin
    s5_u <= sat_uv(sum_u);
    s5_v <= sat_uv(sum_v);
    s5_w <= wid_full[HALF_W-1:0];
    s5_h <= hgt_full[HALF_W-1:0];
  end

  // ---- s6, s7: rotation ----
  logic signed [X1_W-1:0] x1, y1;
  logic [HALF_W-1:0]      s6_w, s6_h, s7_w, s7_h;

  ttac_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .u         (s5_u),
    .v         (s5_v),
    .cos_v     (cfg.cos_v),
    .sin_v     (cfg.sin_v),
    .out_valid (rot_valid),
    .x1        (x1),
    .y1        (y1)
  );

  always_ff @(posedge clk) begin
    s6_w <= s5_w;
    s6_h <= s5_h;
    s7_w <= s6_w;
    s7_h <= s6_h;
  end

  // ---- s8: strict-inside compare ----
  logic signed [CMP_W-1:0] tx, ntx, atx, ty, aty, wz, hz;
  logic                    x_ok, y_ok;

  assign tx  = CMP_W'(x1) <<< 1;
  assign ntx = -tx;
  assign atx = tx[CMP_W-1] ? ntx : tx;
  assign ty  = CMP_W'(y1) <<< 1;
  assign aty = ty[CMP_W-1] ? -ty : ty;
  assign wz  = $signed(CMP_W'(s7_w));
  assign hz  = $signed(CMP_W'(s7_h));

  always_comb begin
    y_ok = aty < hz;
    case (cfg.mode)
      MODE_POS_JAW: x_ok = tx < wz;   // only the positive jaw
      MODE_NEG_JAW: x_ok = ntx < wz;  // only the negative jaw
      default:      x_ok = atx < wz;  // both jaws
    endcase
  end

  always_ff @(posedge clk) begin
    inside_res <= x_ok && y_ok;
  end

endmodule

/* rtl/ttac_check.sv */
// ----------------------------------------------------------------------------
// ttac_check
// Port-level checks for the aperture test, bound to the top level.
// ----------------------------------------------------------------------------
module ttac_check import ttac_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             inside_res,
  input logic             wr_en,
  input logic [IDX_W-1:0] wr_index
);

  logic [LATENCY-1:0] acc_hist;
  logic               size_written;

  // request history, cleared by reset like the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_hist <= '0;
    end else begin
      acc_hist <= {acc_hist[LATENCY-2:0], start && !busy};
    end
  end

  // sizes reset to zero: nothing fits until one is written
  always_ff @(posedge clk) begin
    if (rst) begin
      size_written <= 1'b0;
    end else if (wr_en && (wr_index == REG_ENTRY_SIZE || wr_index == REG_EXIT_SIZE)) begin
      size_written <= 1'b1;
    end
  end

  // one answer per request, fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == acc_hist[LATENCY-1])
    else $error("done does not match a request taken %0d cycles earlier", LATENCY);

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("done asserted right after reset");

  // zero-sized opening admits nothing
  a_zero_aperture: assert property (@(posedge clk) disable iff (rst)
    (done && !size_written) |-> !inside_res)
    else $error("inside reported with zero aperture size");

endmodule

bind tilted_tapered_aperture_check ttac_check u_ttac_check (.*);

/* tb/tb_tilted_tapered_aperture_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilted_tapered_aperture_check
// Self-checking bench for the tilted tapered aperture check. A directed table
// covers reset state, edges of the opening in every mode, tapering past the
// exit, zero length and odd rotations. Random phases follow with a fresh
// geometry each, points aimed at and around the opening, and bursty requests.
// Answers are checked against a typed-in value or an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_tilted_tapered_aperture_check;
  import ttac_pkg::*;

  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 44;

  localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic        [31:0] Z_MAX = 32'hFFFF_FFFF;

  // Offset-corrected point is clamped to [-2^34, 2^34 - 1] before rotating
  localparam longint UV_REACH = 64'sd1 << 34;

  typedef logic signed [127:0] wide_t;

  // Geometries used by the directed table
  typedef enum logic [3:0] {
    GEOM_RESET,        // nothing written: zero-size opening
    GEOM_TWO_SIDED,    // 2000 x 1000 opening, no tilt
    GEOM_POS_JAW,
    GEOM_NEG_JAW,
    GEOM_TAPER,        // narrows to 1000 x 500 over 2^20 nm, exit shifted
    GEOM_NO_LENGTH,    // tapered mode with zero inverse length
    GEOM_QUARTER_TURN, // cos 0, sin 1
    GEOM_TRIG_MAX,     // cos = sin = most positive, extreme sizes/offsets
    GEOM_TRIG_MIN      // cos = sin = most negative
  } geom_t;

  typedef struct packed {
    geom_t              geom;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] z;
    logic               known;   // answer typed in below
    logic               want_in;
  } probe_row_t;

  localparam int N_PROBES = 27;

  probe_row_t probes [N_PROBES] = '{
    // after reset the opening has zero size: everything hits
    '{GEOM_RESET,        32'sd0,    32'sd0,    32'd0,       1'b1, 1'b0},
    '{GEOM_RESET,        X_MAX,     X_MAX,     Z_MAX,       1'b1, 1'b0},
    '{GEOM_RESET,        X_MIN,     X_MIN,     32'd0,       1'b1, 1'b0},
    // strict edges of a 2000 x 1000 opening
    '{GEOM_TWO_SIDED,    32'sd0,    32'sd0,    32'd12345,   1'b1, 1'b1},
    '{GEOM_TWO_SIDED,    32'sd999,  32'sd499,  32'd0,       1'b1, 1'b1},
    '{GEOM_TWO_SIDED,    32'sd1000, 32'sd0,    32'd0,       1'b1, 1'b0},
    '{GEOM_TWO_SIDED,    32'sd0,    -32'sd500, 32'd0,       1'b1, 1'b0},
    '{GEOM_TWO_SIDED,    -32'sd999, -32'sd499, Z_MAX,       1'b1, 1'b1},
    '{GEOM_TWO_SIDED,    X_MIN,     32'sd0,    32'd0,       1'b1, 1'b0},
    // one-sided: the far side is open
    '{GEOM_POS_JAW,      X_MIN,     32'sd0,    32'd0,       1'b1, 1'b1},
    '{GEOM_POS_JAW,      32'sd999,  32'sd0,    32'd0,       1'b1, 1'b1},
    '{GEOM_POS_JAW,      32'sd1000, 32'sd0,    32'd0,       1'b1, 1'b0},
    '{GEOM_NEG_JAW,      X_MAX,     32'sd0,    32'd0,       1'b1, 1'b1},
    '{GEOM_NEG_JAW,      -32'sd999, 32'sd0,    32'd0,       1'b1, 1'b1},
    '{GEOM_NEG_JAW,      -32'sd1000,32'sd0,    32'd0,       1'b1, 1'b0},
    // taper: entry, middle, exit, past the exit
    '{GEOM_TAPER,        32'sd0,    32'sd0,    32'd0,       1'b0, 1'b0},
    '{GEOM_TAPER,        32'sd700,  32'sd0,    32'h0008_0000, 1'b0, 1'b0},
    '{GEOM_TAPER,        32'sd500,  32'sd0,    32'h0010_0000, 1'b0, 1'b0},
    '{GEOM_TAPER,        32'sd560,  32'sd240,  Z_MAX,       1'b0, 1'b0},
    // zero inverse length: entry values hold at any z
    '{GEOM_NO_LENGTH,    32'sd999,  32'sd0,    Z_MAX,       1'b1, 1'b1},
    '{GEOM_NO_LENGTH,    32'sd1000, 32'sd0,    Z_MAX,       1'b1, 1'b0},
    '{GEOM_QUARTER_TURN, 32'sd400,  32'sd900,  32'd0,       1'b0, 1'b0},
    '{GEOM_QUARTER_TURN, 32'sd900,  32'sd400,  32'd0,       1'b0, 1'b0},
    // unnormalized rotations with extreme everything
    '{GEOM_TRIG_MAX,     X_MAX,     X_MIN,     Z_MAX,       1'b0, 1'b0},
    '{GEOM_TRIG_MAX,     X_MIN,     X_MAX,     32'd0,       1'b0, 1'b0},
    '{GEOM_TRIG_MIN,     X_MIN,     X_MIN,     32'd0,       1'b0, 1'b0},
    '{GEOM_TRIG_MIN,     X_MAX,     X_MAX,     Z_MAX,       1'b0, 1'b0}
  };

  // DUT ports, inputs known from time zero
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [COORD_WIDTH-1:0] pos_x = '0;
  logic signed [COORD_WIDTH-1:0] pos_y = '0;
  logic        [Z_W-1:0]         pos_z = '0;
  logic                          done;
  logic                          inside_res;
  logic                          wr_en = 1'b0;
  logic [IDX_W-1:0]              wr_index = '0;
  logic [CFG_W-1:0]              wr_data = '0;

  // Typed-in answer travels with the request, driven like a port
  logic row_known  = 1'b0;
  logic row_expect = 1'b0;

  // Bench copy of the aperture registers, reset values
  mode_t       ap_mode      = MODE_UNALIGNED;
  logic [63:0] ap_rotation  = 64'h0000_0000_4000_0000;
  logic [31:0] ap_inv_len   = '0;
  logic [63:0] ap_entry_sz  = '0;
  logic [63:0] ap_exit_sz   = '0;
  logic [63:0] ap_entry_off = '0;
  logic [63:0] ap_exit_off  = '0;

  logic inside_queue [$];  // answers owed by the block, oldest first
  int   fail_count = 0;

  tilted_tapered_aperture_check dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .done       (done),
    .inside_res (inside_res),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic wide_t clamp_uv(wide_t a);
    if (a >= UV_REACH) return UV_REACH - 1;
    if (a < -UV_REACH) return -UV_REACH;
    return a;
  endfunction

  // Strict inside test at the current register copy. All math is done at
  // 128 bits so products and floors are exact; >>> on signed is floor.
  function automatic logic aperture_inside(logic signed [31:0] px, logic signed [31:0] py,
                                           logic [31:0] pz);
    wide_t frac, xe, ye, ox, oy, w, h, u, v, c, s, x1, y1, ay, ax, zz, il;
    logic  hit_free;
    xe = $signed(ap_entry_off[31:0]);
    ye = $signed(ap_entry_off[63:32]);
    w  = ap_entry_sz[31:0];
    h  = ap_entry_sz[63:32];
    ox = -xe;
    oy = -ye;
    if (ap_mode == MODE_TAPERED) begin
      zz = pz;
      il = ap_inv_len;
      frac = (zz * il) >>> 32;
      if (frac > FRAC_ONE) frac = FRAC_ONE;   // hold exit values past the exit
      ox = ((frac * (xe - wide_t'($signed(ap_exit_off[31:0])))) >>> FRAC_BITS) - xe;
      oy = ((frac * (ye - wide_t'($signed(ap_exit_off[63:32])))) >>> FRAC_BITS) - ye;
      w  = ((frac * (wide_t'(ap_exit_sz[31:0]) - w)) >>> FRAC_BITS) + w;
      h  = ((frac * (wide_t'(ap_exit_sz[63:32]) - h)) >>> FRAC_BITS) + h;
    end
    u = clamp_uv(wide_t'(px) + ox);
    v = clamp_uv(wide_t'(py) + oy);
    c = $signed(ap_rotation[31:0]);
    s = $signed(ap_rotation[63:32]);
    x1 = (u * c - v * s) >>> TRIG_FRAC_BITS;
    y1 = (u * s + v * c) >>> TRIG_FRAC_BITS;
    ay = (y1 < 0) ? -y1 : y1;
    ax = (x1 < 0) ? -x1 : x1;
    hit_free = (2 * ay < h);
    case (ap_mode)
      MODE_POS_JAW: hit_free = hit_free && (2 * x1 < w);
      MODE_NEG_JAW: hit_free = hit_free && (-2 * x1 < w);
      default:      hit_free = hit_free && (2 * ax < w);
    endcase
    return hit_free;
  endfunction

  // --------------------------------------------------------------------------
  // Result check and request capture, both on pre-edge values
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : score
    logic want;
    if (!rst) begin
      // pop before push: a result can never belong to this edge's request
      if (done) begin
        if (inside_queue.size() == 0) begin
          $error("inside_res: result with no request outstanding, got %0b", inside_res);
          fail_count++;
        end else begin
          want = inside_queue.pop_front();
          if (inside_res !== want) begin
            $error("inside_res: expected %0b, got %0b", want, inside_res);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        inside_queue.push_back(row_known ? row_expect : aperture_inside(pos_x, pos_y, pos_z));
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      REG_MODE:         ap_mode      = mode_t'(val[1:0]);
      REG_ROTATION:     ap_rotation  = val;
      REG_INV_LENGTH:   ap_inv_len   = val[31:0];
      REG_ENTRY_SIZE:   ap_entry_sz  = val;
      REG_EXIT_SIZE:    ap_exit_sz   = val;
      REG_ENTRY_OFFSET: ap_entry_off = val;
      REG_EXIT_OFFSET:  ap_exit_off  = val;
      default: ;
    endcase
  endtask

  task automatic program_aperture(mode_t m, logic [63:0] rot, logic [31:0] inv,
                                  logic [63:0] es, logic [63:0] xs,
                                  logic [63:0] eo, logic [63:0] xo);
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_ROTATION, rot);
    write_reg(REG_INV_LENGTH, 64'(inv));
    write_reg(REG_ENTRY_SIZE, es);
    write_reg(REG_EXIT_SIZE, xs);
    write_reg(REG_ENTRY_OFFSET, eo);
    write_reg(REG_EXIT_OFFSET, xo);
    wr_en <= 1'b0;
  endtask

  // Drop start and wait until every answer owed has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (inside_queue.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] z,
                            logic known, logic want);
    start      <= 1'b1;
    pos_x      <= x;
    pos_y      <= y;
    pos_z      <= z;
    row_known  <= known;
    row_expect <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_geometry(geom_t g);
    // exit values differ from entry so non-tapered modes prove they ignore them
    case (g)
      GEOM_TWO_SIDED:
        program_aperture(MODE_UNALIGNED, 64'h4000_0000, 32'h1000_0000,
                         {32'd1000, 32'd2000}, {32'd500, 32'd1000}, '0, {-32'sd50, 32'sd100});
      GEOM_POS_JAW:
        program_aperture(MODE_POS_JAW, 64'h4000_0000, 32'h1000_0000,
                         {32'd1000, 32'd2000}, {32'd500, 32'd1000}, '0, {-32'sd50, 32'sd100});
      GEOM_NEG_JAW:
        program_aperture(MODE_NEG_JAW, 64'h4000_0000, 32'h1000_0000,
                         {32'd1000, 32'd2000}, {32'd500, 32'd1000}, '0, {-32'sd50, 32'sd100});
      GEOM_TAPER:
        program_aperture(MODE_TAPERED, 64'h4000_0000, 32'h1000_0000,
                         {32'd1000, 32'd2000}, {32'd500, 32'd1000}, '0, {-32'sd50, 32'sd100});
      GEOM_NO_LENGTH:
        program_aperture(MODE_TAPERED, 64'h4000_0000, 32'd0,
                         {32'd1000, 32'd2000}, {32'd500, 32'd1000}, '0, {-32'sd50, 32'sd100});
      GEOM_QUARTER_TURN:
        program_aperture(MODE_UNALIGNED, {32'h4000_0000, 32'h0}, 32'd0,
                         {32'd1000, 32'd2000}, '0, '0, '0);
      GEOM_TRIG_MAX:
        program_aperture(MODE_TAPERED, {2{32'h7FFF_FFFF}}, Z_MAX,
                         '1, '0, {X_MAX, X_MIN}, {X_MIN, X_MAX});
      GEOM_TRIG_MIN:
        program_aperture(MODE_TAPERED, {2{32'h8000_0000}}, 32'h0001_0000,
                         '0, '1, {X_MIN, X_MAX}, {X_MAX, X_MIN});
      default: ;
    endcase
  endtask

  // Random value in [center - span, center + span], wrapping at 32 bits
  function automatic logic [31:0] jitter_about(logic [31:0] center, logic [31:0] span);
    longint d;
    d = $urandom_range(0, span);
    if ($urandom_range(0, 1) != 0) d = -d;
    return center + d[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : run_stimulus
    geom_t       geom_now;
    int          burst_left;
    bit          extreme;
    mode_t       m;
    real         ang;
    longint      cq, sq;
    logic [63:0] rot, es, xs, eo, xo;
    logic [31:0] inv, sc, px, py, pz;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reload the geometry whenever the row asks for a new one
    geom_now = GEOM_RESET;
    foreach (probes[i]) begin
      if (probes[i].geom != geom_now) begin
        wait_idle();
        load_geometry(probes[i].geom);
        geom_now = probes[i].geom;
      end
      send_point(probes[i].x, probes[i].y, probes[i].z, probes[i].known, probes[i].want_in);
    end

    // Random phases: mode cycles so all four get several phases;
    // first and last phase use corner register values
    burst_left = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      m = mode_t'(p % 4);
      extreme = (p == 0) || (p == N_PHASES - 1);
      if (p == 0) begin
        rot = {32'h8000_0000, 32'h7FFF_FFFF};
        inv = Z_MAX;
        es  = '1;
        xs  = '1;
        eo  = {X_MIN, X_MIN};
        xo  = {X_MIN, X_MIN};
      end else if (extreme) begin
        rot = {32'h7FFF_FFFF, 32'h8000_0000};
        inv = 32'd1;
        es  = '0;
        xs  = '1;
        eo  = {X_MAX, X_MAX};
        xo  = {X_MIN, X_MAX};
      end else begin
        case ($urandom_range(0, 4))
          0: rot = 64'h4000_0000;
          1, 2: begin
            // normalized tilt, any angle
            ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            cq  = $rtoi($cos(ang) * 1073741824.0);
            sq  = $rtoi($sin(ang) * 1073741824.0);
            rot = {sq[31:0], cq[31:0]};
          end
          3: rot = {$urandom, $urandom};
          default: rot = {($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000,
                          ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000};
        endcase
        case ($urandom_range(0, 3))
          0:       inv = '0;
          3:       inv = $urandom;
          default: inv = $urandom >> $urandom_range(0, 20);
        endcase
        sc = 32'd1 << $urandom_range(4, 30);
        es = {32'($urandom_range(0, sc)), 32'($urandom_range(0, sc))};
        xs = {32'($urandom_range(0, sc)), 32'($urandom_range(0, sc))};
        sc = 32'd1 << $urandom_range(0, 28);
        eo = {jitter_about('0, sc), jitter_about('0, sc)};
        xo = {jitter_about('0, sc), jitter_about('0, sc)};
      end
      program_aperture(m, rot, inv, es, xs, eo, xo);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts of back-to-back requests, sometimes with a gap between them
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
        burst_left--;
        // most points land around the opening; a few are anywhere
        if ($urandom_range(0, 9) < 2) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else begin
          px = jitter_about(eo[31:0], es[31:0]);
          py = jitter_about(eo[63:32], es[63:32]);
          pz = $urandom >> $urandom_range(0, 31);
        end
        send_point(px, py, pz, 1'b0, 1'b0);
      end
    end

    wait_idle();
    repeat (LATENCY + 4) @(posedge clk);
    if (inside_queue.size() != 0) begin
      $error("inside_res: %0d answers never arrived", inside_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tilted_tapered_aperture_check regression: pass");
    end else begin
      $display("tilted_tapered_aperture_check regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the length of a correct run
  initial begin
    #2_000_000;
    $display("tilted_tapered_aperture_check regression: fail");
    $finish;
  end

endmodule
